// ----- rtl/dtti_pkg.sv -----
// Shared types and constants for the decimal text to integer block.
// Depends on nothing; imported by every module of the block.
package dtti_pkg;

  // Character codes.
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // Largest magnitude that can take another digit: (2^64-1) / 10.
  localparam logic [63:0] MAG_LIMIT = 64'd1844674407370955161;
  // Largest digit allowed on top of MAG_LIMIT.
  localparam logic [3:0]  MAG_LIMIT_DIGIT = 4'd5;

  // Config register word addresses (paddr[2]).
  localparam logic REG_SIGNED_MODE  = 1'b0;
  localparam logic REG_WIDTH_SELECT = 1'b1;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned OUT_TDATA_W = 72;  // 64 value + 3 error, padded to bytes

  typedef enum logic [1:0] {
    WIDTH_8  = 2'd0,
    WIDTH_16 = 2'd1,
    WIDTH_32 = 2'd2,
    WIDTH_64 = 2'd3
  } width_e;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_EMPTY     = 3'd1,
    ERR_SIGN_ONLY = 3'd2,
    ERR_BAD_CHAR  = 3'd3,
    ERR_RANGE     = 3'd4
  } err_e;

  // One input word as it moves through the front stage.
  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       last;
  } item_t;

  // Running parse state; also the snapshot handed to the result stage.
  typedef struct packed {
    logic [DATA_W-1:0] magnitude;
    logic              overflowed;
    logic              negative;
    logic              bad_char_seen;
    logic [1:0]        chars_seen;
    logic              sign_seen;
  } acc_t;

endpackage

// ----- rtl/dtti_skid.sv -----
// Input register with a one-word skid buffer; keeps the upstream ready registered.
// Depends on dtti_pkg.
module dtti_skid import dtti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  item_t in_item_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  output item_t out_item_o,
  input  logic  out_ready_i
);

  logic  main_valid_q, skid_valid_q;
  item_t main_q, skid_q;
  logic  accept;

  assign in_ready_o  = !skid_valid_q;
  assign accept      = in_valid_i && !skid_valid_q;
  assign out_valid_o = main_valid_q;
  assign out_item_o  = main_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_ready_i) begin
        skid_valid_q <= 1'b0;
      end
    end else if (!main_valid_q || out_ready_i) begin
      main_valid_q <= accept;
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_ready_i) begin
        main_q <= skid_q;
      end
    end else if (!main_valid_q || out_ready_i) begin
      main_q <= in_item_i;
    end else if (accept) begin
      skid_q <= in_item_i;
    end
  end

  // The skid slot only fills behind a held word.
  a_skid_behind_main: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> main_valid_q)
    else $error("skid word without main word");

endmodule

// ----- rtl/dtti_accum.sv -----
// Per-character parse: shift-add by ten, overflow and sign tracking, snapshot on last.
// Depends on dtti_pkg.
module dtti_accum import dtti_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  adv_i,
  input  logic  signed_mode_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  snap_valid_o,
  output acc_t  snap_o
);

  acc_t        acc_q, acc_d;
  acc_t        snap_q;
  logic        snap_valid_q;
  logic        is_digit, is_sign, take_sign, ovf_hit;
  logic [3:0]  digit;
  logic [63:0] mag_x10;
  logic        fire;

  assign fire = adv_i && item_valid_i;

  always_comb begin
    is_digit  = (item_i.char_code >= CH_ZERO) && (item_i.char_code <= CH_NINE);
    is_sign   = (item_i.char_code == CH_PLUS) || (item_i.char_code == CH_MINUS);
    take_sign = (acc_q.chars_seen == 2'd0) && signed_mode_i && is_sign;
    digit     = item_i.char_code[3:0];
    // m*10 + d as m*8 + m*2 + d
    mag_x10   = {acc_q.magnitude[60:0], 3'b000} + {acc_q.magnitude[62:0], 1'b0}
              + {60'd0, digit};
    ovf_hit   = (acc_q.magnitude > MAG_LIMIT)
             || ((acc_q.magnitude == MAG_LIMIT) && (digit > MAG_LIMIT_DIGIT));

    acc_d = acc_q;
    if (item_i.has_char) begin
      if (take_sign) begin
        acc_d.sign_seen = 1'b1;
        acc_d.negative  = (item_i.char_code == CH_MINUS);
      end else if (is_digit) begin
        acc_d.magnitude  = mag_x10;
        acc_d.overflowed = acc_q.overflowed | ovf_hit;
      end else begin
        acc_d.bad_char_seen = 1'b1;
      end
      if (acc_q.chars_seen != 2'd2) begin
        acc_d.chars_seen = acc_q.chars_seen + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q        <= '0;
      snap_valid_q <= 1'b0;
    end else if (adv_i) begin
      snap_valid_q <= item_valid_i && item_i.last;
      if (item_valid_i) begin
        acc_q <= item_i.last ? '0 : acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && item_i.last) begin
      snap_q <= acc_d;
    end
  end

  assign snap_valid_o = snap_valid_q;
  assign snap_o       = snap_q;

  // A final word starts the next text from scratch.
  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_i.last) |=> (acc_q == '0))
    else $error("parse state not cleared after final word");

  // A sign is only ever taken as a counted character.
  a_sign_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q.sign_seen |-> (acc_q.chars_seen != 2'd0))
    else $error("sign flagged with no character counted");

endmodule

// ----- rtl/dtti_final.sv -----
// Range check, error priority and two's-complement result; holds the output register.
// Depends on dtti_pkg.
module dtti_final import dtti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic        signed_mode_i,
  input  width_e      width_select_i,
  input  logic        snap_valid_i,
  input  acc_t        snap_i,
  output logic        out_valid_o,
  output logic [63:0] value_o,
  output err_e        error_code_o
);

  logic [63:0] half, umax, limit, neg_mag;
  logic [63:0] value_d, value_q;
  err_e        err_d, err_q;
  logic        out_valid_q;

  always_comb begin
    case (width_select_i)
      WIDTH_8:  begin half = 64'h80;                 umax = 64'hFF;                 end
      WIDTH_16: begin half = 64'h8000;               umax = 64'hFFFF;               end
      WIDTH_32: begin half = 64'h8000_0000;          umax = 64'hFFFF_FFFF;          end
      WIDTH_64: begin half = 64'h8000_0000_0000_0000; umax = 64'hFFFF_FFFF_FFFF_FFFF; end
      default:  begin half = 64'h8000_0000_0000_0000; umax = 64'hFFFF_FFFF_FFFF_FFFF; end
    endcase
    if (signed_mode_i) begin
      limit = snap_i.negative ? half : half - 64'd1;
    end else begin
      limit = umax;
    end
    neg_mag = 64'd0 - snap_i.magnitude;

    value_d = 64'd0;
    if (snap_i.chars_seen == 2'd0) begin
      err_d = ERR_EMPTY;
    end else if ((snap_i.chars_seen == 2'd1) && snap_i.sign_seen) begin
      err_d = ERR_SIGN_ONLY;
    end else if (snap_i.bad_char_seen) begin
      err_d = ERR_BAD_CHAR;
    end else if (snap_i.overflowed || (snap_i.magnitude > limit)) begin
      err_d = ERR_RANGE;
    end else begin
      err_d   = ERR_NONE;
      value_d = snap_i.negative ? neg_mag : snap_i.magnitude;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_i) begin
      out_valid_q <= snap_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && snap_valid_i) begin
      value_q <= value_d;
      err_q   <= err_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign error_code_o = err_q;

  // Any error forces a zero value.
  a_err_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (err_q != ERR_NONE)) |-> (value_q == 64'd0))
    else $error("nonzero value with error code");

  // A text with no character reports empty.
  a_empty_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && snap_valid_i && (snap_i.chars_seen == 2'd0)) |=> (err_q == ERR_EMPTY))
    else $error("empty text not reported as empty");

endmodule

// ----- rtl/decimal_text_to_integer.sv -----
// Top level of the decimal text to integer converter.
// Depends on dtti_pkg, dtti_skid, dtti_accum and dtti_final.
//
// Usage:
//   Input stream: one ASCII character per word on s_axis_tdata, s_axis_tuser set
//   when the word carries a character (clear with tlast marks empty text), and
//   s_axis_tlast on the final word of the text. Nothing comes out for words
//   without tlast. Each final word gives one result word on the output stream:
//   the 64-bit two's-complement value in tdata[63:0] (zero on error) and the
//   error code in tdata[66:64].
//   Config (APB, byte address 0: signed_mode, 4: width_select) must be written
//   only while no text is in flight; the block itself does not enforce this.
//   Path: the final word passes the input register, the parse snapshot register
//   and the output register. Throughput: one word per cycle while the output is
//   not stalled, set by the single shift-add by ten in the parse stage.
//   Stall: when a result is waiting and the receiver holds m_axis_tready low, the
//   output register, the parse stage and the input register hold; one more input
//   word lands in the skid slot, then s_axis_tready drops (it is a register output).
//   Reset: clears the parse state, empties the pipeline, and sets config to
//   unsigned mode with 64-bit width.
module decimal_text_to_integer import dtti_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input stream
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [7:0]             s_axis_tdata,   // [7:0] char_code
  input  logic                   s_axis_tuser,   // [0] has_char
  input  logic                   s_axis_tlast,   // last character of the text
  // result stream
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [63:0] value, [66:64] error_code
  // config port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [2:0]             paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic   signed_mode_q;
  width_e width_select_q;
  logic   cfg_write;

  item_t  in_item, a_item;
  logic   a_valid;
  logic   adv;
  logic   snap_valid;
  acc_t   snap;
  logic   out_valid;
  logic [63:0] value;
  err_e   error_code;

  // Config registers: always ready, write on the access cycle.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      signed_mode_q  <= 1'b0;
      width_select_q <= WIDTH_64;
    end else if (cfg_write) begin
      case (paddr[2])
        REG_SIGNED_MODE:  signed_mode_q  <= pwdata[0];
        REG_WIDTH_SELECT: width_select_q <= width_e'(pwdata[1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_SIGNED_MODE:  prdata = {31'd0, signed_mode_q};
      REG_WIDTH_SELECT: prdata = {30'd0, width_select_q};
      default:          prdata = 32'd0;
    endcase
  end

  // The whole pipeline advances when the output register is free or drained.
  assign adv = !out_valid || m_axis_tready;

  assign in_item = '{char_code: s_axis_tdata, has_char: s_axis_tuser, last: s_axis_tlast};

  dtti_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_item_i   (in_item),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (a_valid),
    .out_item_o  (a_item),
    .out_ready_i (adv)
  );

  dtti_accum u_accum (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .adv_i         (adv),
    .signed_mode_i (signed_mode_q),
    .item_valid_i  (a_valid),
    .item_i        (a_item),
    .snap_valid_o  (snap_valid),
    .snap_o        (snap)
  );

  dtti_final u_final (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .signed_mode_i  (signed_mode_q),
    .width_select_i (width_select_q),
    .snap_valid_i   (snap_valid),
    .snap_i         (snap),
    .out_valid_o    (out_valid),
    .value_o        (value),
    .error_code_o   (error_code)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {5'd0, error_code, value};

endmodule
